>>> hdl/obb_sphere_overlap_test_defines.svh
// assertion macros used by the port-level checker
`ifndef OBB_SPHERE_OVERLAP_TEST_DEFINES_SVH
`define OBB_SPHERE_OVERLAP_TEST_DEFINES_SVH
// same-cycle implication, sampled on clk, off while in reset
`define OSO_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define OSO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hdl/oso_pkg.sv
// types and constants of the box/sphere overlap test
`timescale 1ns / 1ps
`default_nettype none
package oso_pkg;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int RES_W      = 32;
	localparam int SUM_W      = 64;
	localparam int ROOT_STAGES = 32;
	// six projection stages, then one stage per root bit
	localparam int PIPE_LAT   = 6 + ROOT_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_EXTENTS    = 3'd3,
		REG_AXIS_ONE   = 3'd4,
		REG_AXIS_TWO   = 3'd5,
		REG_AXIS_THREE = 3'd6
	} reg_idx_t;

	typedef logic [2:0][15:0] vec3_t;

	// control that travels with a beat
	typedef struct packed {
		logic valid;
		logic hit;
		logic sat;
	} tag_t;
endpackage
`default_nettype wire

>>> hdl/oso_proj.sv
// projection, excess, square and sum pipeline (six stages)
`timescale 1ns / 1ps
`default_nettype none
module oso_proj import oso_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_x,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_y,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_z,
	input  wire logic        [RES_W-1:0]       sphere_radius,
	input  wire logic signed [COORD_WIDTH-1:0] center_x,
	input  wire logic signed [COORD_WIDTH-1:0] center_y,
	input  wire logic signed [COORD_WIDTH-1:0] center_z,
	input  wire vec3_t                         extents,
	input  wire vec3_t                         axes [3],
	output tag_t                               tag,
	output logic             [SUM_W-1:0]       sum_sq
);
	localparam int OFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W = OFF_W + 16;
	localparam int DOT_W  = PROD_W + 2;
	localparam int PROJ_W = DOT_W - 14;
	localparam int EXC_W  = (PROJ_W > RES_W + 1) ? PROJ_W : RES_W + 1;

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [OFF_W-1:0] off_s1 [3];
	logic [RES_W-1:0]        rad_s1, rad_s2, rad_s3, rad_s4;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic [PROJ_W-1:0]       mag_s3 [3];
	logic [RES_W-1:0]        exc_s4 [3];
	logic                    sat_s4, sat_s5;
	logic [SUM_W-1:0]        sq_s5 [3];
	logic [SUM_W-1:0]        rsq_s5;

	logic signed [DOT_W-1:0]  dot [3];
	logic signed [PROJ_W-1:0] proj [3];
	logic [PROJ_W-1:0]        mag [3];
	logic [EXC_W-1:0]         exc [3];
	logic [2:0]               exc_sat;
	logic [SUM_W+1:0]         total;
	logic                     sat_all;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot[i] = DOT_W'(prod_s2[i][0]) + DOT_W'(prod_s2[i][1]) + DOT_W'(prod_s2[i][2]);
			proj[i] = dot[i][DOT_W-1:14];
			mag[i] = proj[i][PROJ_W-1] ? PROJ_W'(-proj[i]) : PROJ_W'(proj[i]);
			// empty axis contributes nothing
			if (extents[i] == 16'd0)
				mag[i] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (EXC_W'(mag_s3[i]) > EXC_W'({extents[i], 8'd0}))
				exc[i] = EXC_W'(mag_s3[i]) - EXC_W'({extents[i], 8'd0});
			else
				exc[i] = '0;
			exc_sat[i] = |exc[i][EXC_W-1:RES_W];
		end
	end

	assign total = (SUM_W+2)'(sq_s5[0]) + (SUM_W+2)'(sq_s5[1]) + (SUM_W+2)'(sq_s5[2]);
	assign sat_all = sat_s5 | (|total[SUM_W+1:SUM_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			tag  <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			tag.valid <= v_s5;
			tag.sat   <= sat_all;
			tag.hit   <= !sat_all && (total[SUM_W-1:0] < rsq_s5);
		end
	end

	always_ff @(posedge clk) begin
		off_s1[0] <= OFF_W'(sphere_x) - OFF_W'(center_x);
		off_s1[1] <= OFF_W'(sphere_y) - OFF_W'(center_y);
		off_s1[2] <= OFF_W'(sphere_z) - OFF_W'(center_z);
		rad_s1 <= sphere_radius;
		rad_s2 <= rad_s1;
		rad_s3 <= rad_s2;
		rad_s4 <= rad_s3;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				prod_s2[i][k] <= off_s1[k] * $signed(axes[i][k]);
			mag_s3[i] <= mag[i];
			exc_s4[i] <= exc[i][RES_W-1:0];
			sq_s5[i]  <= SUM_W'(exc_s4[i]) * SUM_W'(exc_s4[i]);
		end
		sat_s4 <= |exc_sat;
		sat_s5 <= sat_s4;
		rsq_s5 <= SUM_W'(rad_s4) * SUM_W'(rad_s4);
		sum_sq <= total[SUM_W-1:0];
	end
endmodule
`default_nettype wire

>>> hdl/oso_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module oso_sqrt import oso_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tag_t             in_tag,
	input  wire logic [SUM_W-1:0] radicand,
	output tag_t                  out_tag,
	output logic [RES_W-1:0]      root
);
	localparam int REM_W = SUM_W + 1;

	tag_t             tag_s  [ROOT_STAGES+1];
	logic [REM_W-1:0] rem_s  [ROOT_STAGES+1];
	logic [RES_W-1:0] root_s [ROOT_STAGES+1];

	assign tag_s[0]  = in_tag;
	assign rem_s[0]  = REM_W'(radicand);
	assign root_s[0] = '0;

	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
		localparam int B = ROOT_STAGES - 1 - g;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			trial = (REM_W'(root_s[g]) << (B + 1)) | (REM_W'(1) << (2 * B));
			take  = rem_s[g] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_s[g+1] <= '0;
			else
				tag_s[g+1] <= tag_s[g];
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= take ? rem_s[g] - trial : rem_s[g];
			root_s[g+1] <= take ? (root_s[g] | (RES_W'(1) << B)) : root_s[g];
		end
	end

	assign out_tag = tag_s[ROOT_STAGES];
	assign root    = root_s[ROOT_STAGES];
endmodule
`default_nettype wire

>>> hdl/obb_sphere_overlap_test.sv
// top level of the oriented box versus sphere overlap test
`timescale 1ns / 1ps
`default_nettype none
// fully pipelined: one sphere beat may start in every cycle and busy stays low.
// each beat yields exactly one result after it passes through six projection
// stages and one stage per bit of the 32-bit root, shown on hit and
// box_distance for the single cycle in which done is high; the receiver cannot
// stall, so a result must be taken when it appears. box registers are written
// through cfg_we/cfg_index/cfg_data and must only change while no beat is in
// flight. box_distance is the floored root of the summed squared excess,
// all ones when it saturates (hit is then low).
module obb_sphere_overlap_test import oso_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	output logic                               done,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_x,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_y,
	input  wire logic signed [COORD_WIDTH-1:0] sphere_z,
	input  wire logic        [RES_W-1:0]       sphere_radius,
	output logic                               hit,
	output logic             [RES_W-1:0]       box_distance,
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);
	logic signed [COORD_WIDTH-1:0] center_x_q, center_y_q, center_z_q;
	vec3_t                         extents_q;
	vec3_t                         axes_q [3];
	tag_t                          proj_tag, root_tag;
	logic [SUM_W-1:0]              sum_sq;
	logic [RES_W-1:0]              root;

	// box registers; reset leaves the axes on x, y, z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			extents_q  <= '0;
			axes_q[0]  <= {16'd0, 16'd0, 16'd16384};
			axes_q[1]  <= {16'd0, 16'd16384, 16'd0};
			axes_q[2]  <= {16'd16384, 16'd0, 16'd0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X:   center_x_q <= cfg_data[COORD_WIDTH-1:0];
				REG_CENTER_Y:   center_y_q <= cfg_data[COORD_WIDTH-1:0];
				REG_CENTER_Z:   center_z_q <= cfg_data[COORD_WIDTH-1:0];
				REG_EXTENTS:    extents_q  <= cfg_data;
				REG_AXIS_ONE:   axes_q[0]  <= cfg_data;
				REG_AXIS_TWO:   axes_q[1]  <= cfg_data;
				REG_AXIS_THREE: axes_q[2]  <= cfg_data;
				default: ;  // unmapped index ignored
			endcase
		end
	end

	// projection onto the box axes, excess, squares and their sum
	oso_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj (
		.clk(clk), .arst_n(arst_n), .in_valid(start & ~busy),
		.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
		.sphere_radius(sphere_radius),
		.center_x(center_x_q), .center_y(center_y_q), .center_z(center_z_q),
		.extents(extents_q), .axes(axes_q),
		.tag(proj_tag), .sum_sq(sum_sq)
	);

	// bit-per-stage square root
	oso_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_tag(proj_tag), .radicand(sum_sq),
		.out_tag(root_tag), .root(root)
	);

	assign busy         = 1'b0;
	assign done         = root_tag.valid;
	assign hit          = root_tag.valid & root_tag.hit;
	assign box_distance = root_tag.sat ? {RES_W{1'b1}} : root;
endmodule
`default_nettype wire

>>> hdl/oso_checker.sv
// port-level checker bound to the overlap test top level
`timescale 1ns / 1ps
`default_nettype none
`include "obb_sphere_overlap_test_defines.svh"
module oso_checker import oso_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic hit
);
	// every result comes from a beat started a fixed latency before
	`OSO_ASSERT_IMPLY(a_done_has_start, done, $past(start && !busy, PIPE_LAT))
	// every accepted beat yields a result after the fixed latency
	`OSO_ASSERT_IMPLY(a_start_gives_done, start && !busy, ##PIPE_LAT done)
	// hit only shows with a result
	`OSO_ASSERT_IMPLY(a_hit_in_result, hit, done)
	// the pipeline never refuses a beat
	`OSO_ASSERT_NEXT(a_never_busy, 1'b1, !busy)
endmodule

bind obb_sphere_overlap_test oso_checker u_oso_checker (.*);
`default_nettype wire

>>> tb/obb_sphere_overlap_test_checker.sv
// checker for the box/sphere overlap test: predicts each result and compares it
`timescale 1ns / 1ps
module obb_sphere_overlap_test_checker import oso_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic                  done,
	input  logic signed [31:0]    sphere_x,
	input  logic signed [31:0]    sphere_y,
	input  logic signed [31:0]    sphere_z,
	input  logic        [31:0]    sphere_radius,
	input  logic                  hit,
	input  logic        [31:0]    box_distance,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);
	typedef struct packed {
		logic        hit;
		logic [31:0] box_dist;
	} overlap_t;

	logic signed [31:0] box_ctr [3];
	logic [47:0]        box_ext;
	logic [47:0]        box_axis [3];
	overlap_t           expected_q [$];

	assign pending = expected_q.size();

	// exact floor of the root of a 64-bit value
	function automatic logic [31:0] floor_root(logic [63:0] v);
		logic [31:0] r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			logic [31:0] t;
			t = r | (32'd1 << b);
			if ({32'd0, t} * {32'd0, t} <= v) r = t;
		end
		return r;
	endfunction

	function automatic overlap_t predict_overlap(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz, logic [31:0] rad);
		overlap_t res;
		logic signed [33:0] off [3];
		logic [64:0] sum;
		logic sat;
		sat = 0;
		sum = 0;
		off[0] = 34'(sx) - 34'(box_ctr[0]);
		off[1] = 34'(sy) - 34'(box_ctr[1]);
		off[2] = 34'(sz) - 34'(box_ctr[2]);
		for (int i = 0; i < 3; i++) begin
			logic [15:0] e;
			logic signed [63:0] dot, proj;
			logic [63:0] mag, lim, excess;
			e = box_ext[16*i +: 16];
			if (e != 0) begin
				dot = 0;
				for (int k = 0; k < 3; k++)
					dot += 64'(off[k]) * 64'($signed(box_axis[i][16*k +: 16]));
				proj = dot >>> 14; // arithmetic shift floors toward minus infinity
				mag = proj < 0 ? 64'(-proj) : 64'(proj);
				lim = 64'(e) << 8;
				if (mag > lim) begin
					excess = mag - lim;
					if (excess > 64'hFFFF_FFFF) sat = 1;
					else begin
						sum += 65'(excess * excess);
						if (sum[64]) sat = 1;
					end
				end
			end
		end
		if (sat) begin
			res.hit = 0;
			res.box_dist = 32'hFFFF_FFFF;
		end else begin
			res.hit = sum[63:0] < 64'(rad) * 64'(rad);
			res.box_dist = floor_root(sum[63:0]);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : p_check
		overlap_t want;
		int errs;
		if (!arst_n) begin
			box_ctr[0] <= 0;
			box_ctr[1] <= 0;
			box_ctr[2] <= 0;
			box_ext <= 0;
			box_axis[0] <= 48'd16384;
			box_axis[1] <= 48'd16384 << 16;
			box_axis[2] <= 48'd16384 << 32;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected");
					errs = errs + 1;
				end else begin
					want = expected_q.pop_front();
					if (hit !== want.hit) begin
						$error("hit expected %0d actual %0d", want.hit, hit);
						errs = errs + 1;
					end
					if (box_distance !== want.box_dist) begin
						$error("box_distance expected %h actual %h", want.box_dist,
							box_distance);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (start && !busy)
				expected_q.push_back(predict_overlap(sphere_x, sphere_y, sphere_z, sphere_radius));
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_CENTER_X:   box_ctr[0] <= cfg_data[31:0];
					REG_CENTER_Y:   box_ctr[1] <= cfg_data[31:0];
					REG_CENTER_Z:   box_ctr[2] <= cfg_data[31:0];
					REG_EXTENTS:    box_ext <= cfg_data;
					REG_AXIS_ONE:   box_axis[0] <= cfg_data;
					REG_AXIS_TWO:   box_axis[1] <= cfg_data;
					REG_AXIS_THREE: box_axis[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

>>> tb/tb_obb_sphere_overlap_test.sv
// testbench top: drives spheres and box settings, gives the verdict
`timescale 1ns / 1ps
module tb_obb_sphere_overlap_test;
	import oso_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, hit;
	logic signed [31:0] sphere_x = 0, sphere_y = 0, sphere_z = 0;
	logic [31:0] sphere_radius = 0, box_distance;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CENTER_X;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	int fail_count, pending;
	int cycle_count = 0;
	int send_idle_pct = 10;

	localparam int CYCLE_LIMIT = 200000;

	always #1 clk = ~clk;

	obb_sphere_overlap_test DUT (.*);

	obb_sphere_overlap_test_checker u_checker (.*);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// register write while the pipeline is empty
	task automatic write_reg(reg_idx_t idx, logic [47:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// wait for every result plus the pipeline depth
	task automatic drain();
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// one sphere beat; holds until accepted
	task automatic send_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		sphere_x <= x;
		sphere_y <= y;
		sphere_z <= z;
		sphere_radius <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_axis_comp();
		case ($urandom_range(5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			3: return 16'h7FFF;
			4: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// coordinates mostly near the box so hits and misses both occur
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	task automatic random_box(int kind);
		write_reg(REG_CENTER_X, kind == 0 ? 48'h8000_0000 : 48'($signed(rand_coord())));
		write_reg(REG_CENTER_Y, kind == 0 ? 48'h7FFF_FFFF : 48'(rand_coord()));
		write_reg(REG_CENTER_Z, 48'(rand_coord()));
		write_reg(REG_EXTENTS, kind == 0 ? 48'hFFFF_FFFF_FFFF :
			{16'($urandom_range(4096)), 16'($urandom), 16'($urandom_range(1) ? 0 : $urandom)});
		write_reg(REG_AXIS_ONE, {rand_axis_comp(), rand_axis_comp(), rand_axis_comp()});
		write_reg(REG_AXIS_TWO, {rand_axis_comp(), rand_axis_comp(), rand_axis_comp()});
		write_reg(REG_AXIS_THREE, kind == 0 ? 48'hFFFF_FFFF_FFFF :
			{rand_axis_comp(), rand_axis_comp(), rand_axis_comp()});
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: reset box (zero extents) first, then a unit box and extremes
		send_sphere(0, 0, 0, 0);
		send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sphere(32'h0001_0000, 0, 0, 32'h0001_0000);
		drain();
		write_reg(REG_EXTENTS, {16'h0100, 16'h0100, 16'h0100});
		send_sphere(32'h0002_0000, 0, 0, 32'h0001_0000);  // distance equals radius
		send_sphere(32'h0002_0000, 0, 0, 32'h0001_0001);
		send_sphere(32'h0000_8000, 32'h0000_8000, 0, 0);   // inside the box
		send_sphere(32'hFFFE_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
		send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_sphere(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
		drain();
		// extreme box: large offsets and wide axis values to provoke saturation
		random_box(0);
		send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sphere(0, 0, 0, 32'h8000_0000);
		drain();
		// pause until the pipeline is empty, then random phases
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = ph < 3 ? 10 : (ph < 6 ? 50 : 0);
			random_box(1);
			for (int n = 0; n < 100; n++)
				send_sphere(rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
